/* hw/rtl/bulk_packet_message_deframer_core_assert.svh */
// Assertion macros used by the deframer checker.
`ifndef BULK_PACKET_MESSAGE_DEFRAMER_CORE_ASSERT_SVH
`define BULK_PACKET_MESSAGE_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define BPMD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bpmd assertion failed");

// Next-cycle implication, disabled while reset is low.
`define BPMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bpmd assertion failed");

// Next-cycle implication that is checked across reset as well.
`define BPMD_ASSERT_RESET(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bpmd assertion failed");

`endif

/* hw/rtl/bpmd_pkg.sv */
// Package: shared types and constants of the bulk packet message deframer.
package bpmd_pkg;

    localparam int PACKET_BYTES_DEF = 64;
    localparam int BYTE_W           = 8;
    localparam int LEN_W            = 16;
    localparam int CFG_INDEX_W      = 1;

    localparam logic [BYTE_W-1:0] START_TYPE_RST = 8'd0;
    localparam logic [BYTE_W-1:0] CONT_TYPE_RST  = 8'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_TYPE = 1'b0,
        CFG_CONT_TYPE  = 1'b1
    } t_cfg_index;

    // Next start-header byte to take; HDR_DONE when no header is pending.
    typedef enum logic [1:0] {
        HDR_DONE   = 2'd0,
        HDR_SKIP   = 2'd1,
        HDR_LEN_LO = 2'd2,
        HDR_LEN_HI = 2'd3
    } t_hdr_pos;

    typedef struct packed {
        logic [BYTE_W-1:0] start_type_code;
        logic [BYTE_W-1:0] cont_type_code;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              packet_first;
        logic              packet_final;
    } t_in_item;

endpackage

/* hw/rtl/bpmd_if.sv */
// Interfaces: byte input channel, result channel and configuration write channel.
interface bpmd_in_if;
    logic                          valid;
    logic                          ready;
    logic [bpmd_pkg::BYTE_W-1:0]   data_byte;
    logic                          packet_first;
    logic                          packet_final;

    modport source (output valid, output data_byte, output packet_first,
                    output packet_final, input ready);
    modport sink   (input valid, input data_byte, input packet_first,
                    input packet_final, output ready);
endinterface

interface bpmd_out_if;
    logic                          valid;
    logic                          ready;
    logic                          payload_valid;
    logic [bpmd_pkg::BYTE_W-1:0]   payload_byte;
    logic                          message_last;
    logic                          protocol_error;

    modport source (output valid, output payload_valid, output payload_byte,
                    output message_last, output protocol_error, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input message_last, input protocol_error, output ready);
endinterface

interface bpmd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bpmd_pkg::CFG_INDEX_W-1:0]   index;
    logic [bpmd_pkg::BYTE_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/bpmd_cfg_regs.sv */
// Configuration registers: start and continuation type codes.
module bpmd_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bpmd_cfg_if.sink         i_cfg,
    output bpmd_pkg::t_cfg   o_cfg
);

    logic [bpmd_pkg::BYTE_W-1:0] r_start_type;
    logic [bpmd_pkg::BYTE_W-1:0] r_cont_type;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_type <= bpmd_pkg::START_TYPE_RST;
            r_cont_type  <= bpmd_pkg::CONT_TYPE_RST;
        end else if (i_cfg.valid) begin
            unique case (bpmd_pkg::t_cfg_index'(i_cfg.index))
                bpmd_pkg::CFG_START_TYPE: r_start_type <= i_cfg.data;
                bpmd_pkg::CFG_CONT_TYPE:  r_cont_type  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign o_cfg.start_type_code = r_start_type;
    assign o_cfg.cont_type_code  = r_cont_type;

endmodule

/* hw/rtl/bpmd_in_reg.sv */
// Input register stage: captures one byte transfer and holds it until it advances.
module bpmd_in_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bpmd_in_if.sink              i_in,
    input  logic                 i_advance,
    output logic                 o_item_valid,
    output bpmd_pkg::t_in_item   o_item
);

    logic                 r_valid;
    bpmd_pkg::t_in_item   r_item;
    logic                 ready;

    // Take a new byte when empty or when the held one moves on this cycle.
    assign ready      = !r_valid || i_advance;
    assign i_in.ready = ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_in.valid) begin
            r_item.data_byte    <= i_in.data_byte;
            r_item.packet_first <= i_in.packet_first;
            r_item.packet_final <= i_in.packet_final;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

/* hw/rtl/bpmd_parse.sv */
// Deframing state update and result register.
module bpmd_parse #(
    parameter int PACKET_BYTES = bpmd_pkg::PACKET_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    input  bpmd_pkg::t_in_item   i_item,
    input  bpmd_pkg::t_cfg       i_cfg,
    output logic                 o_advance,
    bpmd_out_if.source           o_out
);

    localparam int CNT_W = $clog2(PACKET_BYTES + 1);

    logic                            r_halted,    n_halted;
    logic                            r_msg_open,  n_msg_open;
    logic [bpmd_pkg::LEN_W-1:0]      r_bytes_rem, n_bytes_rem;
    bpmd_pkg::t_hdr_pos              r_hdr_pos,   n_hdr_pos;
    logic [bpmd_pkg::BYTE_W-1:0]     r_len_low,   n_len_low;
    logic [CNT_W-1:0]                r_pkt_cnt,   n_pkt_cnt;
    logic                            r_drop_rest, n_drop_rest;

    logic                            r_out_valid;
    logic                            r_payload_valid;
    logic [bpmd_pkg::BYTE_W-1:0]     r_payload_byte;
    logic                            r_message_last;
    logic                            r_protocol_error;

    logic                            res_valid;
    logic                            res_payload_valid;
    logic [bpmd_pkg::BYTE_W-1:0]     res_payload_byte;
    logic                            res_message_last;
    logic                            res_error;
    logic                            in_packet;
    logic [bpmd_pkg::LEN_W-1:0]      rem_dec;

    assign o_advance = i_item_valid && (!r_out_valid || o_out.ready);
    assign rem_dec   = r_bytes_rem - bpmd_pkg::LEN_W'(1);

    always_comb begin
        n_halted          = r_halted;
        n_msg_open        = r_msg_open;
        n_bytes_rem       = r_bytes_rem;
        n_hdr_pos         = r_hdr_pos;
        n_len_low         = r_len_low;
        n_pkt_cnt         = r_pkt_cnt;
        n_drop_rest       = r_drop_rest;
        res_valid         = 1'b0;
        res_payload_valid = 1'b0;
        res_payload_byte  = '0;
        res_message_last  = 1'b0;
        res_error         = 1'b0;
        in_packet         = 1'b0;

        if (!r_halted) begin
            if (i_item.packet_first) begin
                in_packet = 1'b1;
                if (r_hdr_pos != bpmd_pkg::HDR_DONE) begin
                    res_error = 1'b1;
                end else begin
                    n_pkt_cnt   = CNT_W'(1);
                    n_drop_rest = 1'b0;
                    if (!r_msg_open) begin
                        if (i_item.data_byte != i_cfg.start_type_code) begin
                            res_error = 1'b1;
                        end else begin
                            n_hdr_pos = bpmd_pkg::HDR_SKIP;
                        end
                    end else if (i_item.data_byte != i_cfg.cont_type_code) begin
                        res_error = 1'b1;
                    end
                end
            end else if (r_pkt_cnt != '0) begin
                in_packet = 1'b1;
                // Bytes past the packet size are ignored; only the final mark counts.
                if (r_pkt_cnt < CNT_W'(PACKET_BYTES)) begin
                    n_pkt_cnt = r_pkt_cnt + CNT_W'(1);
                    unique case (r_hdr_pos)
                        bpmd_pkg::HDR_SKIP: begin
                            n_hdr_pos = bpmd_pkg::HDR_LEN_LO;
                        end
                        bpmd_pkg::HDR_LEN_LO: begin
                            n_len_low = i_item.data_byte;
                            n_hdr_pos = bpmd_pkg::HDR_LEN_HI;
                        end
                        bpmd_pkg::HDR_LEN_HI: begin
                            n_hdr_pos   = bpmd_pkg::HDR_DONE;
                            n_bytes_rem = {i_item.data_byte, r_len_low};
                            if ({i_item.data_byte, r_len_low} == '0) begin
                                // Empty message: report completion with no byte.
                                n_msg_open       = 1'b0;
                                n_drop_rest      = 1'b1;
                                res_valid        = 1'b1;
                                res_message_last = 1'b1;
                            end else begin
                                n_msg_open = 1'b1;
                            end
                        end
                        bpmd_pkg::HDR_DONE: begin
                            if (r_msg_open && !r_drop_rest) begin
                                n_bytes_rem       = rem_dec;
                                res_valid         = 1'b1;
                                res_payload_valid = 1'b1;
                                res_payload_byte  = i_item.data_byte;
                                if (rem_dec == '0) begin
                                    n_msg_open       = 1'b0;
                                    n_drop_rest      = 1'b1;
                                    res_message_last = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            if (in_packet && !res_error && i_item.packet_final) begin
                if (n_hdr_pos != bpmd_pkg::HDR_DONE) begin
                    res_error = 1'b1;
                end else begin
                    n_pkt_cnt   = '0;
                    n_drop_rest = 1'b0;
                end
            end

            if (res_error) begin
                n_halted          = 1'b1;
                res_valid         = 1'b1;
                res_payload_valid = 1'b0;
                res_payload_byte  = '0;
                res_message_last  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halted    <= 1'b0;
            r_msg_open  <= 1'b0;
            r_bytes_rem <= '0;
            r_hdr_pos   <= bpmd_pkg::HDR_DONE;
            r_len_low   <= '0;
            r_pkt_cnt   <= '0;
            r_drop_rest <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                r_halted    <= n_halted;
                r_msg_open  <= n_msg_open;
                r_bytes_rem <= n_bytes_rem;
                r_hdr_pos   <= n_hdr_pos;
                r_len_low   <= n_len_low;
                r_pkt_cnt   <= n_pkt_cnt;
                r_drop_rest <= n_drop_rest;
                r_out_valid <= res_valid;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && res_valid) begin
            r_payload_valid  <= res_payload_valid;
            r_payload_byte   <= res_payload_byte;
            r_message_last   <= res_message_last;
            r_protocol_error <= res_error;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.payload_valid  = r_payload_valid;
    assign o_out.payload_byte   = r_payload_byte;
    assign o_out.message_last   = r_message_last;
    assign o_out.protocol_error = r_protocol_error;

endmodule

/* hw/rtl/bulk_packet_message_deframer_core.sv */
// Top level of the bulk packet message deframer.
//
// i_in carries one packet byte per transfer with first/final marks. o_out
// carries zero or one result per byte: a payload byte, an empty-message
// marker (message_last with payload_valid low), or a protocol error.
// i_cfg writes the start type code (index 0) and the continuation type
// code (index 1); write it only while no byte is in flight.
// A result reaches o_out through the input register, then the result
// register. Throughput: one byte per cycle while o_out does not stall,
// set by the combinational state update between those two registers.
// When o_out stalls, the held byte waits in the input register and i_in
// stays ready until that register is full. Reset clears the halt flag,
// all deframing state and both pipeline valids; type codes return to 0/1.
// After a protocol error the block halts: bytes are still taken and
// dropped, and no further result appears until reset.
module bulk_packet_message_deframer_core #(
    parameter int PACKET_BYTES = bpmd_pkg::PACKET_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bpmd_in_if.sink      i_in,
    bpmd_cfg_if.sink     i_cfg,
    bpmd_out_if.source   o_out
);

    bpmd_pkg::t_cfg       cfg;
    bpmd_pkg::t_in_item   item;
    logic                 item_valid;
    logic                 advance;

    bpmd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    bpmd_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_advance    (advance),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    bpmd_parse #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .i_cfg        (cfg),
        .o_advance    (advance),
        .o_out        (o_out)
    );

endmodule

/* hw/rtl/bpmd_checker.sv */
// Port-level checker for the deframer, bound to the top level.
`include "bulk_packet_message_deframer_core_assert.svh"

module bpmd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_payload_valid,
    input logic [bpmd_pkg::BYTE_W-1:0]   i_payload_byte,
    input logic                          i_message_last,
    input logic                          i_protocol_error
);

    // A stalled result stays valid and holds its byte, error and last fields.
    `BPMD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_payload_byte) && $stable(i_protocol_error) && $stable(i_message_last))

    // An error result carries nothing else.
    `BPMD_ASSERT_NOW(a_err_clean, i_clk, i_rst_n, i_out_valid && i_protocol_error, !i_payload_valid && !i_message_last && (i_payload_byte == '0))

    // A result without a byte and without error must close an empty message.
    `BPMD_ASSERT_NOW(a_empty_last, i_clk, i_rst_n, i_out_valid && !i_protocol_error && !i_payload_valid, i_message_last)

    // Once the error transfer completes, the result register must empty.
    `BPMD_ASSERT_NEXT(a_halt_quiet, i_clk, i_rst_n, i_out_valid && i_out_ready && i_protocol_error, !i_out_valid)

    // Reset empties the result register.
    `BPMD_ASSERT_RESET(a_rst_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind bulk_packet_message_deframer_core bpmd_checker u_bpmd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_payload_valid  (o_out.payload_valid),
    .i_payload_byte   (o_out.payload_byte),
    .i_message_last   (o_out.message_last),
    .i_protocol_error (o_out.protocol_error)
);

/* tb/tb.sv */
// Testbench for the deframer core: directed and random packet traffic checked against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                        payload_valid;
        logic [bpmd_pkg::BYTE_W-1:0] payload_byte;
        logic                        message_last;
        logic                        protocol_error;
    } t_out_item;

    typedef logic [bpmd_pkg::BYTE_W-1:0] t_byte_q [$];

    typedef enum int {
        BAD_START_TYPE,
        BAD_CONT_TYPE,
        HEADER_CUT_BY_END,
        HEADER_CUT_BY_START
    } t_fault;

    logic i_clk;
    logic i_rst_n;

    bpmd_in_if  in_if ();
    bpmd_out_if out_if ();
    bpmd_cfg_if cfg_if ();

    bulk_packet_message_deframer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // Deframer state as predicted from the accepted bytes.
    bpmd_pkg::t_cfg              cfg_now;
    bit                          halted;
    bit                          msg_open;
    logic [bpmd_pkg::LEN_W-1:0]  remaining;
    bpmd_pkg::t_hdr_pos          hdr_pos;
    logic [bpmd_pkg::BYTE_W-1:0] len_lo;
    int                          pkt_bytes;
    bit                          dropping;

    t_out_item expected_results [$];
    int        fails;
    int        bytes_sent;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        stall_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("bulk_packet_message_deframer_core verification failed");
        $finish;
    end

    function automatic bit halt_on_error(output t_out_item res);
        halted = 1'b1;
        res = '0;
        res.protocol_error = 1'b1;
        return 1'b1;
    endfunction

    function automatic bit deframe_byte(input bpmd_pkg::t_in_item it, output t_out_item res);
        bit has_res;
        res = '0;
        has_res = 1'b0;
        if (halted)
            return 1'b0;
        if (it.packet_first) begin
            if (hdr_pos != bpmd_pkg::HDR_DONE)
                return halt_on_error(res);
            pkt_bytes = 1;
            dropping = 1'b0;
            if (!msg_open) begin
                if (it.data_byte != cfg_now.start_type_code)
                    return halt_on_error(res);
                hdr_pos = bpmd_pkg::HDR_SKIP;
            end else if (it.data_byte != cfg_now.cont_type_code) begin
                return halt_on_error(res);
            end
        end else begin
            if (pkt_bytes == 0)
                return 1'b0;
            // Bytes past the packet size are ignored, but the final mark still counts.
            if (pkt_bytes < bpmd_pkg::PACKET_BYTES_DEF) begin
                pkt_bytes++;
                case (hdr_pos)
                    bpmd_pkg::HDR_SKIP: hdr_pos = bpmd_pkg::HDR_LEN_LO;
                    bpmd_pkg::HDR_LEN_LO: begin
                        len_lo = it.data_byte;
                        hdr_pos = bpmd_pkg::HDR_LEN_HI;
                    end
                    bpmd_pkg::HDR_LEN_HI: begin
                        hdr_pos = bpmd_pkg::HDR_DONE;
                        remaining = {it.data_byte, len_lo};
                        if (remaining == 0) begin
                            msg_open = 1'b0;
                            dropping = 1'b1;
                            res.message_last = 1'b1;
                            has_res = 1'b1;
                        end else begin
                            msg_open = 1'b1;
                        end
                    end
                    default: begin
                        if (msg_open && !dropping) begin
                            remaining--;
                            res.payload_valid = 1'b1;
                            res.payload_byte = it.data_byte;
                            res.message_last = (remaining == 0);
                            if (remaining == 0) begin
                                msg_open = 1'b0;
                                dropping = 1'b1;
                            end
                            has_res = 1'b1;
                        end
                    end
                endcase
            end
        end
        if (it.packet_final) begin
            if (hdr_pos != bpmd_pkg::HDR_DONE)
                return halt_on_error(res);
            pkt_bytes = 0;
            dropping = 1'b0;
        end
        return has_res;
    endfunction

    // Result side: random ready, plus a long hold-off when stall_left is set.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin : result_check
        t_out_item want;
        forever begin
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no result expected");
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_if.payload_valid !== want.payload_valid) begin
                        $error("payload_valid: expected %0h, got %0h",
                               want.payload_valid, out_if.payload_valid);
                        fails++;
                    end
                    if (out_if.payload_byte !== want.payload_byte) begin
                        $error("payload_byte: expected %0h, got %0h",
                               want.payload_byte, out_if.payload_byte);
                        fails++;
                    end
                    if (out_if.message_last !== want.message_last) begin
                        $error("message_last: expected %0h, got %0h",
                               want.message_last, out_if.message_last);
                        fails++;
                    end
                    if (out_if.protocol_error !== want.protocol_error) begin
                        $error("protocol_error: expected %0h, got %0h",
                               want.protocol_error, out_if.protocol_error);
                        fails++;
                    end
                end
            end
        end
    end

    task automatic send_byte(input logic [bpmd_pkg::BYTE_W-1:0] b, input bit pkt_start,
                             input bit pkt_end);
        bpmd_pkg::t_in_item it;
        t_out_item          res;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.data_byte    <= b;
        in_if.packet_first <= pkt_start;
        in_if.packet_final <= pkt_end;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1)
            @(posedge i_clk);
        it.data_byte = b;
        it.packet_first = pkt_start;
        it.packet_final = pkt_end;
        bytes_sent++;
        if (deframe_byte(it, res))
            expected_results.push_back(res);
    endtask

    // Send head bytes, then random filler up to total bytes.
    task automatic send_packet(input t_byte_q head, input int total, input bit end_mark);
        logic [bpmd_pkg::BYTE_W-1:0] b;
        for (int i = 0; i < total; i++) begin
            b = (i < head.size()) ? head[i] : 8'($urandom);
            send_byte(b, i == 0, end_mark && i == total - 1);
        end
    endtask

    task automatic finish_message(input int max_pkt);
        while (msg_open)
            send_packet('{cfg_now.cont_type_code}, $urandom_range(max_pkt, 1),
                        $urandom_range(9) != 0);
    endtask

    task automatic send_message(input logic [bpmd_pkg::LEN_W-1:0] len, input int max_pkt);
        send_packet('{cfg_now.start_type_code, 8'($urandom), len[7:0], len[15:8]},
                    $urandom_range(max_pkt, 4), $urandom_range(9) != 0);
        finish_message(max_pkt);
    endtask

    // Hold the input idle until every expected result is out, then let the pipe settle.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input bpmd_pkg::t_cfg_index idx,
                             input logic [bpmd_pkg::BYTE_W-1:0] val);
        wait_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (cfg_if.ready !== 1'b1)
            @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        if (idx == bpmd_pkg::CFG_START_TYPE)
            cfg_now.start_type_code = val;
        else
            cfg_now.cont_type_code = val;
    endtask

    task automatic test_directed_cases();
        // empty message, then a stray byte outside any packet
        send_packet('{cfg_now.start_type_code, 8'hAA, 8'h00, 8'h00}, 4, 1'b1);
        send_byte(8'h5A, 1'b0, 1'b1);
        // three-byte message over three packets; surplus bytes dropped
        send_packet('{cfg_now.start_type_code, 8'h00, 8'h03, 8'h00, 8'hFF}, 5, 1'b1);
        send_packet('{cfg_now.cont_type_code}, 1, 1'b1);
        send_packet('{cfg_now.cont_type_code, 8'h00, 8'h80, 8'h7F, 8'h55}, 5, 1'b1);
        // one-byte message with no final mark, then a fresh start packet
        send_packet('{cfg_now.start_type_code, 8'h01, 8'h01, 8'h00, 8'h12}, 5, 1'b0);
        send_packet('{cfg_now.start_type_code, 8'h33, 8'h00, 8'h00}, 4, 1'b1);
        wait_drained();
    endtask

    task automatic test_oversized_packet();
        send_packet('{cfg_now.start_type_code, 8'($urandom), 8'd70, 8'd0},
                    bpmd_pkg::PACKET_BYTES_DEF + 6, 1'b1);
        finish_message(bpmd_pkg::PACKET_BYTES_DEF + 8);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int snd_idle, input int rcv_idle,
                                       input logic [bpmd_pkg::BYTE_W-1:0] start_code,
                                       input logic [bpmd_pkg::BYTE_W-1:0] cont_code);
        int base;
        int pick;
        int max_pkt;
        logic [bpmd_pkg::LEN_W-1:0] len;
        write_reg(bpmd_pkg::CFG_START_TYPE, start_code);
        write_reg(bpmd_pkg::CFG_CONT_TYPE, cont_code);
        send_idle_pct = snd_idle;
        recv_idle_pct = rcv_idle;
        base = bytes_sent;
        while (bytes_sent - base < 30) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                // non-first bytes between messages: stray or surplus
                repeat ($urandom_range(4, 1))
                    send_byte(8'($urandom), 1'b0, $urandom_range(1));
            end else begin
                pick = $urandom_range(99);
                if (pick < 10)
                    len = 0;
                else if (pick < 85)
                    len = bpmd_pkg::LEN_W'($urandom_range(24, 1));
                else
                    len = bpmd_pkg::LEN_W'($urandom_range(200, 25));
                max_pkt = ($urandom_range(9) == 0) ? bpmd_pkg::PACKET_BYTES_DEF + 8
                                                   : $urandom_range(16, 4);
                send_message(len, max_pkt);
            end
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_left = 300;
        send_message(16'd48, bpmd_pkg::PACKET_BYTES_DEF);
        wait_drained();
    endtask

    task automatic test_long_message();
        write_reg(bpmd_pkg::CFG_START_TYPE, 8'($urandom));
        write_reg(bpmd_pkg::CFG_CONT_TYPE, 8'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_message(16'h0100, bpmd_pkg::PACKET_BYTES_DEF);
        wait_drained();
    endtask

    task automatic test_halt_on_error();
        t_fault fault;
        logic [bpmd_pkg::BYTE_W-1:0] mask;
        fault = t_fault'($urandom_range(3));
        mask = 8'(1 << $urandom_range(7));
        case (fault)
            BAD_START_TYPE:
                send_packet('{cfg_now.start_type_code ^ mask}, 3, 1'b1);
            BAD_CONT_TYPE: begin
                send_packet('{cfg_now.start_type_code, 8'h00, 8'd20, 8'd0}, 6, 1'b1);
                send_packet('{cfg_now.cont_type_code ^ mask}, 4, 1'b1);
            end
            HEADER_CUT_BY_END:
                send_packet('{cfg_now.start_type_code}, $urandom_range(3, 1), 1'b1);
            default: begin
                send_packet('{cfg_now.start_type_code}, $urandom_range(3, 1), 1'b0);
                send_packet('{cfg_now.start_type_code}, 4, 1'b1);
            end
        endcase
        // the block stays halted: well-formed traffic yields nothing
        repeat (3)
            send_packet('{cfg_now.start_type_code, 8'h00, 8'd2, 8'd0}, 6, 1'b1);
        wait_drained();
    endtask

    initial begin
        logic [bpmd_pkg::BYTE_W-1:0] shared_code;
        shared_code = 8'($urandom);
        in_if.valid        <= 1'b0;
        in_if.data_byte    <= '0;
        in_if.packet_first <= 1'b0;
        in_if.packet_final <= 1'b0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= bpmd_pkg::CFG_START_TYPE;
        cfg_if.data        <= '0;
        i_rst_n            <= 1'b0;
        cfg_now.start_type_code = bpmd_pkg::START_TYPE_RST;
        cfg_now.cont_type_code  = bpmd_pkg::CONT_TYPE_RST;
        hdr_pos = bpmd_pkg::HDR_DONE;
        send_idle_pct = 16;
        recv_idle_pct = 77;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_oversized_packet();
        test_random_traffic(16, 77, 8'hFF, 8'h00);
        test_random_traffic(77, 16, shared_code, shared_code);
        test_random_traffic(0, 0, 8'h00, 8'hFF);
        test_backpressure();
        test_long_message();
        test_halt_on_error();
        wait_drained();
        if (fails == 0) begin
            $display("bulk_packet_message_deframer_core verification clean");
        end else begin
            $display("bulk_packet_message_deframer_core verification failed");
        end
        $finish;
    end

endmodule
